FILE: sv/mmp_pkg.sv
package mmp_pkg;

  localparam int POINT_COUNT_DEF = 1024;
  localparam int COORD_W = 32;
  localparam int POINT_W = 4 * COORD_W;
  localparam int INDEX_W = 10;
  localparam int IN_DATA_W = 152;
  localparam int OUT_DATA_W = 144;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_PART  = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_W = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WRAP_LO, OP_WRAP_HI, OP_SPAN, OP_MOM_INIT, OP_G_INIT,
    OP_GEND, OP_D, OP_MID, OP_I_INIT, OP_BEST_INIT, OP_J_CMP, OP_I_NEXT,
    OP_G_NEXT, OP_STEP_NEXT, OP_PIVOT, OP_K_INC, OP_KP_INC, OP_SW_LATCH
  } op_t;

  typedef enum logic [2:0] {RD_NONE, RD_LO, RD_I, RD_J, RD_K, RD_SWA, RD_SWB} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_IN, WR_A, WR_B} wr_sel_t;
  typedef enum logic [2:0] {SW_I_BEST, SW_G_MID, SW_LO_HI, SW_K_PLACE, SW_HI_PLACE} sw_sel_t;
  typedef enum logic [2:0] {RES_NONE, RES_ZERO, RES_ERR, RES_READ, RES_LO, RES_PLACE} res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_MOM_INIT, S_MOM_CHK, S_GRP, S_D, S_MID, S_IINIT, S_ICHK,
    S_BEST, S_JCHK, S_JCMP, S_INEXT, S_GNEXT, S_PIV_RD, S_PIV, S_PSW, S_KCHK,
    S_KCMP, S_KPINC, S_PEND, S_SW0, S_SW1, S_SW2, S_SW3, S_DONE
  } state_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    sw_sel_t sw_sel;
    logic    tmp_cap;
    res_t    res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic lo_big;
    logic hi_big;
    logic lo_gt_hi;
    logic lo_eq_hi;
    logic step_le;
    logic g_le_hi;
    logic i_le_mid;
    logic j_le_gend;
    logic k_lt_hi;
    logic less;
  } flags_t;

endpackage

FILE: sv/mmp_ram.sv
module mmp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/mmp_ctrl.sv
module mmp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mmp_pkg::flags_t flags,
  output mmp_pkg::cmd_t   cmd
);

  mmp_pkg::state_t state_r, state_nxt;
  mmp_pkg::state_t ret_r, ret_nxt;
  mmp_pkg::res_t   resk_r, resk_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            fire;

  assign fire = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign in_ready = rst_n && (state_r == mmp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mmp_pkg::S_IDLE;
      ret_r    <= mmp_pkg::S_IDLE;
      resk_r   <= mmp_pkg::RES_ZERO;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      resk_r   <= resk_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    resk_nxt   = resk_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      mmp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = mmp_pkg::S_WRAP;
      end
      mmp_pkg::S_WRAP: begin
        if (!flags.lo_big && !flags.hi_big) begin
          state_nxt = mmp_pkg::S_DONE;
          case (flags.act)
            mmp_pkg::ACT_WRITE: resk_nxt = mmp_pkg::RES_ZERO;
            mmp_pkg::ACT_READ:  resk_nxt = mmp_pkg::RES_READ;
            mmp_pkg::ACT_PART: begin
              if (flags.lo_gt_hi) begin
                resk_nxt = mmp_pkg::RES_ERR;
              end else if (flags.lo_eq_hi) begin
                resk_nxt = mmp_pkg::RES_LO;
              end else begin
                state_nxt = mmp_pkg::S_MOM_INIT;
              end
            end
            default: resk_nxt = mmp_pkg::RES_ZERO;
          endcase
        end
      end
      mmp_pkg::S_MOM_INIT: state_nxt = mmp_pkg::S_MOM_CHK;
      mmp_pkg::S_MOM_CHK: begin
        state_nxt = flags.step_le ? mmp_pkg::S_GRP : mmp_pkg::S_PIV_RD;
      end
      mmp_pkg::S_GRP: begin
        state_nxt = flags.g_le_hi ? mmp_pkg::S_D : mmp_pkg::S_MOM_CHK;
      end
      mmp_pkg::S_D:     state_nxt = mmp_pkg::S_MID;
      mmp_pkg::S_MID:   state_nxt = mmp_pkg::S_IINIT;
      mmp_pkg::S_IINIT: state_nxt = mmp_pkg::S_ICHK;
      mmp_pkg::S_ICHK: begin
        if (flags.i_le_mid) begin
          state_nxt = mmp_pkg::S_BEST;
        end else begin
          state_nxt = mmp_pkg::S_SW0;
          ret_nxt   = mmp_pkg::S_GNEXT;
        end
      end
      mmp_pkg::S_BEST: state_nxt = mmp_pkg::S_JCHK;
      mmp_pkg::S_JCHK: begin
        if (flags.j_le_gend) begin
          state_nxt = mmp_pkg::S_JCMP;
        end else begin
          state_nxt = mmp_pkg::S_SW0;
          ret_nxt   = mmp_pkg::S_INEXT;
        end
      end
      mmp_pkg::S_JCMP:   state_nxt = mmp_pkg::S_JCHK;
      mmp_pkg::S_INEXT:  state_nxt = mmp_pkg::S_ICHK;
      mmp_pkg::S_GNEXT:  state_nxt = mmp_pkg::S_GRP;
      mmp_pkg::S_PIV_RD: state_nxt = mmp_pkg::S_PIV;
      mmp_pkg::S_PIV:    state_nxt = mmp_pkg::S_PSW;
      mmp_pkg::S_PSW: begin
        state_nxt = mmp_pkg::S_SW0;
        ret_nxt   = mmp_pkg::S_KCHK;
      end
      mmp_pkg::S_KCHK: begin
        if (flags.k_lt_hi) begin
          state_nxt = mmp_pkg::S_KCMP;
        end else begin
          state_nxt = mmp_pkg::S_SW0;
          ret_nxt   = mmp_pkg::S_PEND;
        end
      end
      mmp_pkg::S_KCMP: begin
        if (flags.less) begin
          state_nxt = mmp_pkg::S_SW0;
          ret_nxt   = mmp_pkg::S_KPINC;
        end else begin
          state_nxt = mmp_pkg::S_KCHK;
        end
      end
      mmp_pkg::S_KPINC: state_nxt = mmp_pkg::S_KCHK;
      mmp_pkg::S_PEND: begin
        resk_nxt  = mmp_pkg::RES_PLACE;
        state_nxt = mmp_pkg::S_DONE;
      end
      mmp_pkg::S_SW0: state_nxt = mmp_pkg::S_SW1;
      mmp_pkg::S_SW1: state_nxt = mmp_pkg::S_SW2;
      mmp_pkg::S_SW2: state_nxt = mmp_pkg::S_SW3;
      mmp_pkg::S_SW3: state_nxt = ret_r;
      mmp_pkg::S_DONE: begin
        if (fire) begin
          ovalid_nxt = 1'b1;
          state_nxt  = mmp_pkg::S_IDLE;
        end
      end
      default: state_nxt = mmp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = mmp_pkg::OP_NONE;
    cmd.rd_sel  = mmp_pkg::RD_NONE;
    cmd.wr_sel  = mmp_pkg::WR_NONE;
    cmd.sw_sel  = mmp_pkg::SW_I_BEST;
    cmd.tmp_cap = 1'b0;
    cmd.res     = mmp_pkg::RES_NONE;
    case (state_r)
      mmp_pkg::S_IDLE: begin
        if (in_valid) cmd.op = mmp_pkg::OP_LOAD;
      end
      mmp_pkg::S_WRAP: begin
        if (flags.lo_big) begin
          cmd.op = mmp_pkg::OP_WRAP_LO;
        end else if (flags.hi_big) begin
          cmd.op = mmp_pkg::OP_WRAP_HI;
        end else if (flags.act == mmp_pkg::ACT_WRITE) begin
          cmd.wr_sel = mmp_pkg::WR_IN;
        end else if (flags.act == mmp_pkg::ACT_READ) begin
          cmd.rd_sel = mmp_pkg::RD_LO;
        end else begin
          cmd.op = mmp_pkg::OP_SPAN;
        end
      end
      mmp_pkg::S_MOM_INIT: cmd.op = mmp_pkg::OP_MOM_INIT;
      mmp_pkg::S_MOM_CHK: begin
        if (flags.step_le) cmd.op = mmp_pkg::OP_G_INIT;
      end
      mmp_pkg::S_GRP: begin
        cmd.op = flags.g_le_hi ? mmp_pkg::OP_GEND : mmp_pkg::OP_STEP_NEXT;
      end
      mmp_pkg::S_D:     cmd.op = mmp_pkg::OP_D;
      mmp_pkg::S_MID:   cmd.op = mmp_pkg::OP_MID;
      mmp_pkg::S_IINIT: cmd.op = mmp_pkg::OP_I_INIT;
      mmp_pkg::S_ICHK: begin
        if (flags.i_le_mid) begin
          cmd.rd_sel = mmp_pkg::RD_I;
        end else begin
          cmd.op     = mmp_pkg::OP_SW_LATCH;
          cmd.sw_sel = mmp_pkg::SW_G_MID;
        end
      end
      mmp_pkg::S_BEST: cmd.op = mmp_pkg::OP_BEST_INIT;
      mmp_pkg::S_JCHK: begin
        if (flags.j_le_gend) begin
          cmd.rd_sel = mmp_pkg::RD_J;
        end else begin
          cmd.op     = mmp_pkg::OP_SW_LATCH;
          cmd.sw_sel = mmp_pkg::SW_I_BEST;
        end
      end
      mmp_pkg::S_JCMP:   cmd.op = mmp_pkg::OP_J_CMP;
      mmp_pkg::S_INEXT:  cmd.op = mmp_pkg::OP_I_NEXT;
      mmp_pkg::S_GNEXT:  cmd.op = mmp_pkg::OP_G_NEXT;
      mmp_pkg::S_PIV_RD: cmd.rd_sel = mmp_pkg::RD_LO;
      mmp_pkg::S_PIV:    cmd.op = mmp_pkg::OP_PIVOT;
      mmp_pkg::S_PSW: begin
        cmd.op     = mmp_pkg::OP_SW_LATCH;
        cmd.sw_sel = mmp_pkg::SW_LO_HI;
      end
      mmp_pkg::S_KCHK: begin
        if (flags.k_lt_hi) begin
          cmd.rd_sel = mmp_pkg::RD_K;
        end else begin
          cmd.op     = mmp_pkg::OP_SW_LATCH;
          cmd.sw_sel = mmp_pkg::SW_HI_PLACE;
        end
      end
      mmp_pkg::S_KCMP: begin
        if (flags.less) begin
          cmd.op     = mmp_pkg::OP_SW_LATCH;
          cmd.sw_sel = mmp_pkg::SW_K_PLACE;
        end else begin
          cmd.op = mmp_pkg::OP_K_INC;
        end
      end
      mmp_pkg::S_KPINC: cmd.op = mmp_pkg::OP_KP_INC;
      mmp_pkg::S_SW0:   cmd.rd_sel = mmp_pkg::RD_SWA;
      mmp_pkg::S_SW1: begin
        cmd.rd_sel  = mmp_pkg::RD_SWB;
        cmd.tmp_cap = 1'b1;
      end
      mmp_pkg::S_SW2: cmd.wr_sel = mmp_pkg::WR_A;
      mmp_pkg::S_SW3: cmd.wr_sel = mmp_pkg::WR_B;
      mmp_pkg::S_DONE: begin
        if (fire) cmd.res = resk_r;
      end
      default: cmd.op = mmp_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: sv/mmp_dp.sv
module mmp_dp #(
  parameter int POINT_COUNT = mmp_pkg::POINT_COUNT_DEF
) (
  input  logic                                clk,
  input  mmp_pkg::cmd_t                       cmd,
  output mmp_pkg::flags_t                     flags,
  input  logic [1:0]                          in_action,
  input  logic [mmp_pkg::INDEX_W-1:0]         in_first,
  input  logic [mmp_pkg::INDEX_W-1:0]         in_last,
  input  logic [1:0]                          in_axis,
  input  logic [mmp_pkg::POINT_W-1:0]         in_point,
  output logic                                res_status,
  output logic [mmp_pkg::INDEX_W-1:0]         res_pos,
  output logic [mmp_pkg::POINT_W-1:0]         res_point
);

  localparam int AW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int IW = ((AW > mmp_pkg::INDEX_W) ? AW : mmp_pkg::INDEX_W) + 6;
  localparam logic [IW-1:0] PC = IW'(POINT_COUNT);
  localparam logic [IW-1:0] ONE = IW'(1);

  logic [1:0] act_r, act_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [mmp_pkg::POINT_W-1:0] pt_in_r, pt_in_nxt;
  logic [mmp_pkg::POINT_W-1:0] tmp_r, tmp_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, span_r, span_nxt;
  logic [IW-1:0] step_r, step_nxt, step3_r, step3_nxt, step5_r, step5_nxt;
  logic [IW-1:0] g_r, g_nxt, gend_r, gend_nxt, d_r, d_nxt, mid_r, mid_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, best_r, best_nxt;
  logic [IW-1:0] k_r, k_nxt, place_r, place_nxt, swa_r, swa_nxt, swb_r, swb_nxt;
  logic signed [mmp_pkg::COORD_W-1:0] bestv_r, bestv_nxt, pivot_r, pivot_nxt;
  logic status_r, status_nxt;
  logic [mmp_pkg::INDEX_W-1:0] pos_r, pos_nxt;
  logic [mmp_pkg::POINT_W-1:0] outp_r, outp_nxt;

  logic [mmp_pkg::POINT_W-1:0] rdata;
  logic signed [mmp_pkg::COORD_W-1:0] rkey;
  logic [IW-1:0] gend_sum, rd_idx, wr_idx;
  logic [mmp_pkg::POINT_W-1:0] wr_data;
  logic rd_en, wr_en;

  mmp_ram #(.WIDTH(mmp_pkg::POINT_W), .DEPTH(POINT_COUNT)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data)
  );

  always_comb begin
    case (axis_r)
      mmp_pkg::AXIS_X: rkey = rdata[31:0];
      mmp_pkg::AXIS_Y: rkey = rdata[63:32];
      mmp_pkg::AXIS_Z: rkey = rdata[95:64];
      mmp_pkg::AXIS_W: rkey = rdata[127:96];
      default:         rkey = rdata[31:0];
    endcase
  end

  always_comb begin
    rd_en = (cmd.rd_sel != mmp_pkg::RD_NONE);
    case (cmd.rd_sel)
      mmp_pkg::RD_LO:  rd_idx = lo_r;
      mmp_pkg::RD_I:   rd_idx = i_r;
      mmp_pkg::RD_J:   rd_idx = j_r;
      mmp_pkg::RD_K:   rd_idx = k_r;
      mmp_pkg::RD_SWA: rd_idx = swa_r;
      mmp_pkg::RD_SWB: rd_idx = swb_r;
      default:         rd_idx = lo_r;
    endcase
    wr_en = (cmd.wr_sel != mmp_pkg::WR_NONE);
    case (cmd.wr_sel)
      mmp_pkg::WR_IN: begin
        wr_idx  = lo_r;
        wr_data = pt_in_r;
      end
      mmp_pkg::WR_A: begin
        wr_idx  = swa_r;
        wr_data = rdata;
      end
      mmp_pkg::WR_B: begin
        wr_idx  = swb_r;
        wr_data = tmp_r;
      end
      default: begin
        wr_idx  = lo_r;
        wr_data = pt_in_r;
      end
    endcase
  end

  assign gend_sum = g_r + step5_r - ONE;

  always_comb begin
    act_nxt = act_r;   axis_nxt = axis_r;   pt_in_nxt = pt_in_r;
    tmp_nxt = tmp_r;   lo_nxt = lo_r;       hi_nxt = hi_r;
    span_nxt = span_r; step_nxt = step_r;   step3_nxt = step3_r;
    step5_nxt = step5_r; g_nxt = g_r;       gend_nxt = gend_r;
    d_nxt = d_r;       mid_nxt = mid_r;     i_nxt = i_r;
    j_nxt = j_r;       best_nxt = best_r;   k_nxt = k_r;
    place_nxt = place_r; swa_nxt = swa_r;   swb_nxt = swb_r;
    bestv_nxt = bestv_r; pivot_nxt = pivot_r;
    if (cmd.tmp_cap) tmp_nxt = rdata;
    case (cmd.op)
      mmp_pkg::OP_LOAD: begin
        act_nxt   = in_action;
        axis_nxt  = in_axis;
        pt_in_nxt = in_point;
        lo_nxt    = IW'(in_first);
        hi_nxt    = IW'(in_last);
      end
      mmp_pkg::OP_WRAP_LO: lo_nxt = lo_r - PC;
      mmp_pkg::OP_WRAP_HI: hi_nxt = hi_r - PC;
      mmp_pkg::OP_SPAN:    span_nxt = hi_r - lo_r;
      mmp_pkg::OP_MOM_INIT: begin
        step_nxt  = ONE;
        step3_nxt = IW'(3);
        step5_nxt = IW'(5);
      end
      mmp_pkg::OP_G_INIT: g_nxt = lo_r;
      mmp_pkg::OP_GEND:   gend_nxt = (gend_sum > hi_r) ? hi_r : gend_sum;
      mmp_pkg::OP_D:      d_nxt = gend_r - g_r;
      mmp_pkg::OP_MID: begin
        if (d_r >= step3_r) begin
          mid_nxt = g_r + (step_r << 1);
        end else if (d_r >= step_r) begin
          mid_nxt = g_r + step_r;
        end else begin
          mid_nxt = g_r;
        end
      end
      mmp_pkg::OP_I_INIT: i_nxt = g_r;
      mmp_pkg::OP_BEST_INIT: begin
        best_nxt  = i_r;
        bestv_nxt = rkey;
        j_nxt     = i_r + step_r;
      end
      mmp_pkg::OP_J_CMP: begin
        if (rkey < bestv_r) begin
          best_nxt  = j_r;
          bestv_nxt = rkey;
        end
        j_nxt = j_r + step_r;
      end
      mmp_pkg::OP_I_NEXT: i_nxt = i_r + step_r;
      mmp_pkg::OP_G_NEXT: g_nxt = g_r + step5_r;
      mmp_pkg::OP_STEP_NEXT: begin
        step_nxt  = step5_r;
        step3_nxt = (step5_r << 1) + step5_r;
        step5_nxt = (step5_r << 2) + step5_r;
      end
      mmp_pkg::OP_PIVOT: begin
        pivot_nxt = rkey;
        place_nxt = lo_r;
        k_nxt     = lo_r;
      end
      mmp_pkg::OP_K_INC: k_nxt = k_r + ONE;
      mmp_pkg::OP_KP_INC: begin
        k_nxt     = k_r + ONE;
        place_nxt = place_r + ONE;
      end
      mmp_pkg::OP_SW_LATCH: begin
        case (cmd.sw_sel)
          mmp_pkg::SW_I_BEST: begin
            swa_nxt = i_r;     swb_nxt = best_r;
          end
          mmp_pkg::SW_G_MID: begin
            swa_nxt = g_r;     swb_nxt = mid_r;
          end
          mmp_pkg::SW_LO_HI: begin
            swa_nxt = lo_r;    swb_nxt = hi_r;
          end
          mmp_pkg::SW_K_PLACE: begin
            swa_nxt = k_r;     swb_nxt = place_r;
          end
          mmp_pkg::SW_HI_PLACE: begin
            swa_nxt = hi_r;    swb_nxt = place_r;
          end
          default: begin
            swa_nxt = i_r;     swb_nxt = best_r;
          end
        endcase
      end
      default: act_nxt = act_r;
    endcase
  end

  always_comb begin
    status_nxt = status_r;
    pos_nxt    = pos_r;
    outp_nxt   = outp_r;
    case (cmd.res)
      mmp_pkg::RES_ZERO: begin
        status_nxt = 1'b0; pos_nxt = '0; outp_nxt = '0;
      end
      mmp_pkg::RES_ERR: begin
        status_nxt = 1'b1; pos_nxt = '0; outp_nxt = '0;
      end
      mmp_pkg::RES_READ: begin
        status_nxt = 1'b0; pos_nxt = '0; outp_nxt = rdata;
      end
      mmp_pkg::RES_LO: begin
        status_nxt = 1'b0; pos_nxt = lo_r[mmp_pkg::INDEX_W-1:0]; outp_nxt = '0;
      end
      mmp_pkg::RES_PLACE: begin
        status_nxt = 1'b0; pos_nxt = place_r[mmp_pkg::INDEX_W-1:0]; outp_nxt = '0;
      end
      default: status_nxt = status_r;
    endcase
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;     axis_r <= axis_nxt;   pt_in_r <= pt_in_nxt;
    tmp_r <= tmp_nxt;     lo_r <= lo_nxt;       hi_r <= hi_nxt;
    span_r <= span_nxt;   step_r <= step_nxt;   step3_r <= step3_nxt;
    step5_r <= step5_nxt; g_r <= g_nxt;         gend_r <= gend_nxt;
    d_r <= d_nxt;         mid_r <= mid_nxt;     i_r <= i_nxt;
    j_r <= j_nxt;         best_r <= best_nxt;   k_r <= k_nxt;
    place_r <= place_nxt; swa_r <= swa_nxt;     swb_r <= swb_nxt;
    bestv_r <= bestv_nxt; pivot_r <= pivot_nxt;
    status_r <= status_nxt; pos_r <= pos_nxt;   outp_r <= outp_nxt;
  end

  assign flags.act       = act_r;
  assign flags.lo_big    = (lo_r >= PC);
  assign flags.hi_big    = (hi_r >= PC);
  assign flags.lo_gt_hi  = (lo_r > hi_r);
  assign flags.lo_eq_hi  = (lo_r == hi_r);
  assign flags.step_le   = (step_r <= span_r);
  assign flags.g_le_hi   = (g_r <= hi_r);
  assign flags.i_le_mid  = (i_r <= mid_r);
  assign flags.j_le_gend = (j_r <= gend_r);
  assign flags.k_lt_hi   = (k_r < hi_r);
  assign flags.less      = (rkey < pivot_r);

  assign res_status = status_r;
  assign res_pos    = pos_r;
  assign res_point  = outp_r;

endmodule

FILE: sv/median_of_medians_partition_core.sv
// Point store with median-of-medians partition.
// Input channel in_*: one transfer per item. action 0 writes a point, 1 reads
// a point, 2 partitions [first_index, last_index] on sort_axis around the
// median of medians and returns the pivot's final index.
// Output channel out_*: exactly one result transfer per input item, in order.
// One item is in work at a time; in_tready is high only while idle. A
// finished result sits in the output register while the next item is taken.
// A write or read item goes from idle through the wrap state to the done state,
// which loads the output register and goes back to idle for the next item.
// A partition runs through a point memory with one read or one write per
// cycle: each key is read into the memory's read register before use, and
// each whole-point swap is a latch followed by four steps that read both
// points and then write each into the other's place.
// Indices at or above the memory depth wrap, one subtraction per cycle.
// Reset clears the controller and output valid; the point memory is not
// cleared and reads of never-written entries give undefined data.
// When out_tready is low the result holds, and a finished item waits in
// its last state until the output register is free.
module median_of_medians_partition_core #(
  parameter int POINT_COUNT = mmp_pkg::POINT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action[1:0], first_index[11:2], last_index[21:12], sort_axis[23:22],
  // coord_x[55:24], coord_y[87:56], coord_z[119:88], coord_w[151:120]
  input  logic [mmp_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[0], pivot_position[10:1], out_x[42:11], out_y[74:43],
  // out_z[106:75], out_w[138:107], zero fill[143:139]
  output logic [mmp_pkg::OUT_DATA_W-1:0]    out_tdata
);

  mmp_pkg::cmd_t   cmd;
  mmp_pkg::flags_t flags;
  logic                        res_status;
  logic [mmp_pkg::INDEX_W-1:0] res_pos;
  logic [mmp_pkg::POINT_W-1:0] res_point;

  mmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .flags     (flags),
    .cmd       (cmd)
  );

  mmp_dp #(.POINT_COUNT(POINT_COUNT)) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .flags      (flags),
    .in_action  (in_tdata[1:0]),
    .in_first   (in_tdata[11:2]),
    .in_last    (in_tdata[21:12]),
    .in_axis    (in_tdata[23:22]),
    .in_point   (in_tdata[151:24]),
    .res_status (res_status),
    .res_pos    (res_pos),
    .res_point  (res_point)
  );

  assign out_tdata = {5'b0, res_point, res_pos, res_status};

endmodule
